// ===== hdl/rsft_pkg.sv =====
// Shared constants and codes for the resonance sweep frequency tracker.
package rsft_pkg;

    // Default parameter values
    localparam int POINTS_DEF      = 50;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed widths of state and fields
    localparam int CNT_W      = 6;
    localparam int FREQ_W     = 16;
    localparam int POWER_W    = 16;
    localparam int CENTER_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_LEVEL = 2'd2;

    // Request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Fixed stepping mode
    localparam logic [FREQ_W-1:0] FIX_MAX  = 16'd31000;
    localparam logic [FREQ_W-1:0] FIX_MIN  = 16'd26000;
    localparam logic [FREQ_W-1:0] FIX_STEP = 16'd125;

    // Sweep mode
    localparam logic [FREQ_W-1:0] SWP_MAX  = 16'd32000;
    localparam logic [FREQ_W-1:0] SWP_MIN  = 16'd25000;
    localparam logic [FREQ_W-1:0] SWP_HALF = 16'd1500;
    localparam logic [5:0]        SWP_STEP = 6'd60;

    // Reset values of the configuration registers
    localparam logic [CENTER_W-1:0] CENTER_RST = 15'd28500;

endpackage

// ===== hdl/rsft_sweep.sv =====
// Next sweep state for one measured sample: running maximum and band re-centring.
module rsft_sweep
    import rsft_pkg::*;
#(
    parameter int POINTS      = POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic [CNT_W-1:0]       point_count,
    input  logic [SAMPLE_BITS-1:0] best_value,
    input  logic [CNT_W-1:0]       best_index,
    input  logic [FREQ_W-1:0]      band_start,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [CNT_W-1:0]       point_count_next,
    output logic [SAMPLE_BITS-1:0] best_value_next,
    output logic [CNT_W-1:0]       best_index_next,
    output logic [FREQ_W-1:0]      band_start_next,
    output logic [FREQ_W-1:0]      freq_next
);

    logic [SAMPLE_BITS-1:0] best_val_upd;
    logic [CNT_W-1:0]       best_idx_upd;
    logic [CNT_W-1:0]       count_inc;
    logic                   band_done;
    logic [2*CNT_W-1:0]     peak_offset;
    logic [FREQ_W+1:0]      peak_sum;
    logic [FREQ_W-1:0]      new_start;
    logic [2*CNT_W-1:0]     freq_offset;
    logic [FREQ_W:0]        freq_sum;

    always_comb
    begin
        // Keep the first strict maximum of the band.
        if (sample > best_value)
        begin
            best_val_upd = sample;
            best_idx_upd = point_count;
        end
        else
        begin
            best_val_upd = best_value;
            best_idx_upd = best_index;
        end

        count_inc = point_count + CNT_W'(1);
        band_done = (count_inc >= CNT_W'(POINTS));

        // Peak frequency; the new start is the peak less half a band, clamped.
        peak_offset = {{CNT_W{1'b0}}, best_idx_upd} * {{CNT_W{1'b0}}, SWP_STEP};
        peak_sum    = {2'b00, band_start}
                      + {{(FREQ_W+2-2*CNT_W){1'b0}}, peak_offset};
        if (peak_sum > (FREQ_W+2)'(SWP_MAX) + (FREQ_W+2)'(SWP_HALF))
            new_start = SWP_MAX - SWP_HALF;
        else if (peak_sum < (FREQ_W+2)'(SWP_MIN) + (FREQ_W+2)'(SWP_HALF))
            new_start = SWP_MIN;
        else
            new_start = FREQ_W'(peak_sum - (FREQ_W+2)'(SWP_HALF));

        if (band_done)
        begin
            point_count_next = '0;
            best_value_next  = '0;
            best_index_next  = '0;
            band_start_next  = new_start;
        end
        else
        begin
            point_count_next = count_inc;
            best_value_next  = best_val_upd;
            best_index_next  = best_idx_upd;
            band_start_next  = band_start;
        end

        // Frequency of the next point in the band.
        freq_offset = {{CNT_W{1'b0}}, point_count_next} * {{CNT_W{1'b0}}, SWP_STEP};
        freq_sum    = {{(FREQ_W+1-2*CNT_W){1'b0}}, freq_offset} + {1'b0, band_start_next};
        freq_next   = freq_sum[FREQ_W-1:0];
    end

endmodule

// ===== hdl/resonance_sweep_frequency_tracker.sv =====
// Top level of the resonance sweep frequency tracker with its stream and configuration ports.
//
// Each input word (a start request or a tick carrying a power sample) yields exactly one
// output word holding the drive frequency, drive power and drive enable. The state update
// is a single combinational pass into the state registers and the output register, so a
// word is accepted whenever the output register is empty or being read; its result appears in
// the cycle after it. The single output register sets the rate, one word per cycle when
// downstream takes results. Configuration writes take effect at the following edge.
module resonance_sweep_frequency_tracker
    import rsft_pkg::*;
#(
    parameter int POINTS      = POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [((SAMPLE_BITS+1+7)/8)*8-1:0] s_axis_tdata,  // power_on, power_sample
    input  logic                  s_axis_tuser,                // req_type
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata   // drive_freq, drive_power, drive_enable
);

    // Configuration registers
    logic                   sweep_mode_reg;
    logic [CENTER_W-1:0]    center_freq_reg;
    logic [POWER_W-1:0]     power_level_reg;

    // Tracker state
    logic                   running_reg, running_next;
    logic [CNT_W-1:0]       point_count_reg, point_count_next;
    logic [SAMPLE_BITS-1:0] best_value_reg, best_value_next;
    logic [CNT_W-1:0]       best_index_reg, best_index_next;
    logic [FREQ_W-1:0]      band_start_reg, band_start_next;
    logic [FREQ_W-1:0]      current_freq_reg, current_freq_next;

    // Output register
    logic                   out_valid_reg;
    logic [FREQ_W-1:0]      out_freq_reg, out_freq_next;
    logic [POWER_W-1:0]     out_power_reg, out_power_next;
    logic                   out_enable_reg, out_enable_next;

    // Input word fields
    logic                   req_type;
    logic                   power_on;
    logic [SAMPLE_BITS-1:0] power_sample;
    logic                   in_accept;

    // Sweep unit results
    logic [CNT_W-1:0]       swp_count;
    logic [SAMPLE_BITS-1:0] swp_best_value;
    logic [CNT_W-1:0]       swp_best_index;
    logic [FREQ_W-1:0]      swp_band_start;
    logic [FREQ_W-1:0]      swp_freq;

    // Fixed stepping and start values
    logic [FREQ_W:0]        fix_sum;
    logic [FREQ_W-1:0]      fix_freq;
    logic [FREQ_W-1:0]      start_band;

    assign req_type     = s_axis_tuser;
    assign power_on     = s_axis_tdata[0];
    assign power_sample = s_axis_tdata[SAMPLE_BITS:1];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_enable_reg, out_power_reg, out_freq_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_mode_reg  <= 1'b0;
            center_freq_reg <= CENTER_RST;
            power_level_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SWEEP_MODE:  sweep_mode_reg  <= cfg_wdata[0];
                CFG_CENTER_FREQ: center_freq_reg <= cfg_wdata[CENTER_W-1:0];
                CFG_POWER_LEVEL: power_level_reg <= cfg_wdata[POWER_W-1:0];
                default:         ;
            endcase
        end
    end

    // Running maximum and band re-centring
    rsft_sweep #(
        .POINTS      (POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sweep (
        .point_count      (point_count_reg),
        .best_value       (best_value_reg),
        .best_index       (best_index_reg),
        .band_start       (band_start_reg),
        .sample           (power_sample),
        .point_count_next (swp_count),
        .best_value_next  (swp_best_value),
        .best_index_next  (swp_best_index),
        .band_start_next  (swp_band_start),
        .freq_next        (swp_freq)
    );

    // Fixed stepping with wrap, and the first band start of a sweep
    always_comb
    begin
        fix_sum = {1'b0, current_freq_reg} + {1'b0, FIX_STEP};
        if (fix_sum > {1'b0, FIX_MAX})
            fix_freq = FIX_MIN;
        else
            fix_freq = fix_sum[FREQ_W-1:0];

        if ({1'b0, center_freq_reg} >= SWP_HALF)
            start_band = {1'b0, center_freq_reg} - SWP_HALF;
        else
            start_band = '0;
    end

    // Next state and result for the word being accepted
    always_comb
    begin
        running_next      = running_reg;
        point_count_next  = point_count_reg;
        best_value_next   = best_value_reg;
        best_index_next   = best_index_reg;
        band_start_next   = band_start_reg;
        current_freq_next = current_freq_reg;
        out_enable_next   = 1'b0;

        if (req_type == REQ_START)
        begin
            running_next    = 1'b1;
            out_enable_next = 1'b1;
            if (sweep_mode_reg)
            begin
                point_count_next  = '0;
                best_value_next   = '0;
                best_index_next   = '0;
                band_start_next   = start_band;
                current_freq_next = start_band;
            end
            else
            begin
                current_freq_next = FIX_MIN;
            end
        end
        else if (running_reg)
        begin
            if (power_on)
            begin
                out_enable_next = 1'b1;
                if (sweep_mode_reg)
                begin
                    point_count_next  = swp_count;
                    best_value_next   = swp_best_value;
                    best_index_next   = swp_best_index;
                    band_start_next   = swp_band_start;
                    current_freq_next = swp_freq;
                end
                else
                begin
                    current_freq_next = fix_freq;
                end
            end
            else
            begin
                running_next = 1'b0;
            end
        end

        // A stopped drive reports zero frequency and power.
        out_freq_next  = out_enable_next ? current_freq_next : '0;
        out_power_next = out_enable_next ? power_level_reg : '0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg      <= 1'b0;
            point_count_reg  <= '0;
            best_value_reg   <= '0;
            best_index_reg   <= '0;
            band_start_reg   <= '0;
            current_freq_reg <= FIX_MIN;
        end
        else if (in_accept)
        begin
            running_reg      <= running_next;
            point_count_reg  <= point_count_next;
            best_value_reg   <= best_value_next;
            best_index_reg   <= best_index_next;
            band_start_reg   <= band_start_next;
            current_freq_reg <= current_freq_next;
        end
    end

    // Output word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_freq_reg   <= out_freq_next;
            out_power_reg  <= out_power_next;
            out_enable_reg <= out_enable_next;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the resonance sweep frequency tracker stream block.
module tb_top
    import rsft_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no word moving on either stream before the run is abandoned
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_WORDS = 1000;

    // One drive word as it leaves the block: drive_freq lowest, drive_enable highest
    typedef struct packed {
        logic                enable;
        logic [POWER_W-1:0]  power;
        logic [FREQ_W-1:0]   freq;
    } drive_word_t;

    // Tracks the tracker's state, predicts each drive word and compares what arrives.
    class drive_word_check;
        logic                sweep_on;
        logic [CENTER_W-1:0] center;
        logic [POWER_W-1:0]  level;
        logic                running;
        logic [CNT_W-1:0]    point_cnt;
        logic [15:0]         peak_val;
        logic [CNT_W-1:0]    peak_idx;
        logic [FREQ_W-1:0]   band_lo;
        logic [FREQ_W-1:0]   freq;
        drive_word_t         drive_words_due[$];
        int                  errors;

        function new();
            sweep_on  = 1'b0;
            center    = CENTER_RST;
            level     = '0;
            running   = 1'b0;
            point_cnt = '0;
            peak_val  = '0;
            peak_idx  = '0;
            band_lo   = '0;
            freq      = FIX_MIN;
            errors    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SWEEP_MODE:  sweep_on = val[0];
                CFG_CENTER_FREQ: center = val[CENTER_W-1:0];
                CFG_POWER_LEVEL: level = val;
                default: ;
            endcase
        endfunction

        // Advance the predicted state by one accepted request and queue its drive word.
        function void take_request(logic req, logic pon, logic [15:0] sample);
            logic        active;
            int          s;
            drive_word_t want;
            active = 1'b0;
            if (req == REQ_START) begin
                running = 1'b1;
                if (sweep_on) begin
                    point_cnt = '0;
                    peak_val  = '0;
                    peak_idx  = '0;
                    band_lo   = ({1'b0, center} >= SWP_HALF) ? {1'b0, center} - SWP_HALF
                                                              : 16'd0;
                    freq      = band_lo;
                end
                else begin
                    freq = FIX_MIN;
                end
                active = 1'b1;
            end
            else if (running) begin
                if (pon) begin
                    if (sweep_on) begin
                        // Keep the first strict maximum of the band
                        if (sample > peak_val) begin
                            peak_val = sample;
                            peak_idx = point_cnt;
                        end
                        point_cnt = point_cnt + 1'b1;
                        // End of band: re-centre on the peak and clamp
                        if (point_cnt >= POINTS_DEF) begin
                            s = int'(band_lo) + int'(peak_idx) * int'(SWP_STEP) - int'(SWP_HALF);
                            if (s > int'(SWP_MAX))
                                s = int'(SWP_MAX) - int'(SWP_HALF);
                            else if (s < int'(SWP_MIN))
                                s = int'(SWP_MIN);
                            band_lo   = s[15:0];
                            point_cnt = '0;
                            peak_val  = '0;
                            peak_idx  = '0;
                        end
                        s = int'(point_cnt) * int'(SWP_STEP) + int'(band_lo);
                        freq = s[15:0];
                    end
                    else begin
                        s = int'(freq) + int'(FIX_STEP);
                        if (s > int'(FIX_MAX))
                            s = int'(FIX_MIN);
                        freq = s[15:0];
                    end
                    active = 1'b1;
                end
                else begin
                    running = 1'b0;
                end
            end
            if (active)
                want = '{enable: 1'b1, power: level, freq: freq};
            else
                want = '0;
            drive_words_due.push_back(want);
        endfunction

        // Compare an arriving drive word with the oldest prediction.
        function void compare_drive(logic [39:0] data);
            drive_word_t got;
            drive_word_t want;
            got = data[32:0];
            if (drive_words_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: drive word %h arrived with none predicted", $realtime, data);
            end
            else begin
                want = drive_words_due.pop_front();
                if (got.freq !== want.freq || got.power !== want.power
                    || got.enable !== want.enable) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: drive word mismatch: expected freq %0d power %0d en %0b,",
                                 $realtime, want.freq, want.power, want.enable,
                                 " got freq %0d power %0d en %0b",
                                 got.freq, got.power, got.enable);
                end
            end
        endfunction

        function int outstanding();
            return drive_words_due.size();
        endfunction

        function bit failed();
            return errors != 0 || drive_words_due.size() != 0;
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata = '0;   // power_on, power_sample
    logic                  s_axis_tuser = 1'b0; // req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;        // drive_freq, drive_power, drive_enable

    drive_word_check drive_chk = new();

    int   burst_left = 0;
    int   words_sent = 0;
    int   quiet_cycles = 0;
    int   sink_mode = 0;
    int   sink_span = 0;
    logic [7:0] sink_phase = '0;

    resonance_sweep_frequency_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Receiver readiness: steady, coin-toss, one in four, or long stalls
    always @(posedge clk)
    begin
        if (sink_span == 0) begin
            sink_mode <= $urandom_range(0, 3);
            sink_span <= $urandom_range(20, 200);
        end
        else begin
            sink_span <= sink_span - 1;
        end
        sink_phase <= sink_phase + 1'b1;
        case (sink_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (sink_phase[1:0] == 2'd0);
            default: m_axis_tready <= (sink_phase[4:0] >= 5'd24);
        endcase
    end

    // Note accepted requests and check accepted drive words
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                drive_chk.take_request(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[16:1]);
            if (m_axis_tvalid && m_axis_tready)
                drive_chk.compare_drive(m_axis_tdata);
        end
    end

    // Watchdog on cycles in which no word moves
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("resonance_sweep_frequency_tracker regression: fail");
                    $finish;
                end
            end
        end
    end

    // Present one request word, with a random gap at the start of most bursts
    task automatic send_word(input logic req, input logic pon, input logic [15:0] sample);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'd0, sample, pon};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait until every predicted drive word has been taken
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (drive_chk.outstanding() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        drive_chk.set_register(idx, val);
        @(posedge clk);
    endtask

    // A start (usually) followed by ticks whose samples follow one band shape
    task automatic play_run();
        bit          do_start;
        int          n;
        int          shape;
        int          target;
        int          pos;
        logic        pon;
        logic [15:0] base;
        logic [15:0] smp;
        do_start = ($urandom_range(0, 9) != 0);
        if (do_start) begin
            send_word(REQ_START, 1'($urandom_range(0, 1)), 16'($urandom));
            words_sent++;
        end
        n      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(50, 130);
        shape  = $urandom_range(0, 4);
        target = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : POINTS_DEF - 1)
                                            : $urandom_range(0, POINTS_DEF - 1);
        base   = 16'($urandom);
        for (int k = 0; k < n; k++) begin
            pos = k % POINTS_DEF;
            case (shape)
                0: smp = 16'($urandom);
                1: smp = '0;
                2: smp = base;
                3: smp = (pos == target) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                         : 16'($urandom_range(0, 16'hFF00));
                default: smp = 16'($urandom_range(0, 3));
            endcase
            pon = ($urandom_range(0, 199) != 0);
            send_word(REQ_TICK, pon, smp);
            words_sent++;
        end
        // Often stop the drive, then a few ticks that find the block idle
        if ($urandom_range(0, 1) == 0) begin
            send_word(REQ_TICK, 1'b0, 16'($urandom));
            words_sent++;
            repeat ($urandom_range(0, 3))
                send_word(REQ_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fixed mode from reset: idle ticks, start with power off ignored, steps, stop
        send_word(REQ_TICK, 1'b1, 16'hFFFF);
        send_word(REQ_TICK, 1'b0, 16'h0000);
        send_word(REQ_START, 1'b0, 16'h0000);
        send_word(REQ_TICK, 1'b1, 16'h0000);
        send_word(REQ_TICK, 1'b1, 16'hFFFF);
        send_word(REQ_TICK, 1'b1, 16'hAAAA);
        send_word(REQ_TICK, 1'b0, 16'h5555);
        send_word(REQ_TICK, 1'b1, 16'h1234);
        settle();

        // Sweep at the top centre with full power, equal samples for the strict maximum
        write_reg(CFG_POWER_LEVEL, 16'hFFFF);
        write_reg(CFG_SWEEP_MODE, 16'd1);
        write_reg(CFG_CENTER_FREQ, 16'd32000);
        send_word(REQ_START, 1'b1, 16'h0000);
        send_word(REQ_TICK, 1'b1, 16'h0000);
        send_word(REQ_TICK, 1'b1, 16'hFFFF);
        send_word(REQ_TICK, 1'b1, 16'hFFFF);
        send_word(REQ_TICK, 1'b1, 16'h0001);
        settle();

        // Mode change while running: fixed steps from the sweep frequency, past the wrap
        write_reg(CFG_SWEEP_MODE, 16'd0);
        send_word(REQ_TICK, 1'b1, 16'h0000);
        send_word(REQ_TICK, 1'b1, 16'h0000);
        send_word(REQ_TICK, 1'b1, 16'h0000);
        settle();

        // Low centre saturates the band start at zero
        write_reg(CFG_SWEEP_MODE, 16'd1);
        write_reg(CFG_CENTER_FREQ, 16'd1000);
        write_reg(CFG_POWER_LEVEL, 16'h5A5A);
        send_word(REQ_START, 1'b1, 16'h0000);
        send_word(REQ_TICK, 1'b1, 16'h0000);
        send_word(REQ_TICK, 1'b1, 16'h0000);
        send_word(REQ_START, 1'b1, 16'hFFFF);
        settle();

        // Random phases: a fresh mix of settings, then a run of requests
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_SWEEP_MODE, 16'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 5))
                    0:       write_reg(CFG_CENTER_FREQ, 16'd26500);
                    1:       write_reg(CFG_CENTER_FREQ, 16'd32000);
                    2, 3:    write_reg(CFG_CENTER_FREQ, 16'($urandom_range(26500, 32000)));
                    4:       write_reg(CFG_CENTER_FREQ, 16'($urandom_range(0, 1499)));
                    default: write_reg(CFG_CENTER_FREQ, 16'($urandom));
                endcase
            end
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 3))
                    0:       write_reg(CFG_POWER_LEVEL, 16'd0);
                    1:       write_reg(CFG_POWER_LEVEL, 16'hFFFF);
                    default: write_reg(CFG_POWER_LEVEL, 16'($urandom));
                endcase
            end
            play_run();
            settle();
        end

        repeat (10) @(posedge clk);
        if (drive_chk.failed())
            $display("resonance_sweep_frequency_tracker regression: fail");
        else
            $display("resonance_sweep_frequency_tracker regression: pass");
        $finish;
    end

endmodule
